// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the hash unit RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define CHK_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition must never be true outside reset.
`define CHK_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define CHK_ASSERT(lbl, clk, rst, prop, msg)
`define CHK_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

// ===== rtl/mur2_pkg.sv =====
// ---------------------------------------------------------------------------
// mur2_pkg
// Constants, operation codes, command type and tail mask shared by the hash unit.
// ---------------------------------------------------------------------------
`default_nettype none

package mur2_pkg;

   localparam logic [31:0] MUR_MUL  = 32'h5bd1e995;
   localparam logic [31:0] MUR_SEED = 32'h0badcafe;
   localparam int unsigned MIX_SHIFT = 24;
   localparam int unsigned FIN_SHIFT_A = 13;
   localparam int unsigned FIN_SHIFT_B = 15;

   // Datapath operations issued by the controller.
   localparam logic [2:0] OP_NONE = 3'd0;
   localparam logic [2:0] OP_LOAD = 3'd1;
   localparam logic [2:0] OP_MIXK = 3'd2;
   localparam logic [2:0] OP_MIXH = 3'd3;
   localparam logic [2:0] OP_TAIL = 3'd4;
   localparam logic [2:0] OP_FIN  = 3'd5;
   localparam logic [2:0] OP_EMIT = 3'd6;

   typedef struct packed {
      logic [2:0] op;
      logic       first;
   } cmd_type;

   // Keeps the valid bytes of a partial word.
   function automatic logic [31:0] tail_mask(input logic [1:0] cnt);
      logic [31:0] m;
      case (cnt)
         2'd1: begin
            m = 32'h000000ff;
         end
         2'd2: begin
            m = 32'h0000ffff;
         end
         2'd3: begin
            m = 32'h00ffffff;
         end
         default: begin
            m = 32'h00000000;
         end
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/mur2_datapath.sv =====
// ---------------------------------------------------------------------------
// mur2_datapath
// Hash registers around one shared constant multiplier.
// ---------------------------------------------------------------------------
`default_nettype none

module mur2_datapath (
   input  wire logic             clock,
   input  wire mur2_pkg::cmd_type cmd,
   input  wire logic [31:0]      req_word_data,
   input  wire logic [1:0]       req_byte_count,
   input  wire logic [31:0]      req_key_length,
   output logic [31:0]           rsp_hash_value
);
   import mur2_pkg::*;

   logic [31:0] h_ff, h_in;
   logic [31:0] k_ff, k_in;
   logic [31:0] word_ff, word_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [31:0] hash_ff, hash_in;
   logic [31:0] mul_a;
   logic [31:0] mul_p;

   // Operand selection for the single multiplier.
   always_comb begin
      case (cmd.op)
         OP_LOAD: begin
            mul_a = req_word_data;
         end
         OP_MIXK: begin
            mul_a = k_ff ^ (k_ff >> MIX_SHIFT);
         end
         OP_TAIL: begin
            mul_a = h_ff ^ (word_ff & tail_mask(cnt_ff));
         end
         OP_FIN: begin
            mul_a = h_ff ^ (h_ff >> FIN_SHIFT_A);
         end
         default: begin
            mul_a = h_ff;
         end
      endcase
   end

   assign mul_p = mul_a * MUR_MUL;

   always_comb begin
      h_in    = h_ff;
      k_in    = k_ff;
      word_in = word_ff;
      cnt_in  = cnt_ff;
      hash_in = hash_ff;
      case (cmd.op)
         OP_LOAD: begin
            k_in    = mul_p;
            word_in = req_word_data;
            cnt_in  = req_byte_count;
            if (cmd.first) begin
               h_in = MUR_SEED ^ req_key_length;
            end
         end
         OP_MIXK: begin
            k_in = mul_p;
         end
         OP_MIXH: begin
            h_in = mul_p ^ k_ff;
         end
         OP_TAIL: begin
            h_in = mul_p;
         end
         OP_FIN: begin
            h_in = mul_p;
         end
         OP_EMIT: begin
            hash_in = h_ff ^ (h_ff >> FIN_SHIFT_B);
         end
         default: begin
            h_in = h_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      h_ff    <= h_in;
      k_ff    <= k_in;
      word_ff <= word_in;
      cnt_ff  <= cnt_in;
      hash_ff <= hash_in;
   end

   assign rsp_hash_value = hash_ff;

endmodule

`default_nettype wire

// ===== rtl/mur2_ctrl.sv =====
// ---------------------------------------------------------------------------
// mur2_ctrl
// Sequencer that steps the datapath through word mixing and finalization.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mur2_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [2:0]        req_byte_count,
   input  wire logic              req_first_word,
   input  wire logic              req_last_word,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output mur2_pkg::cmd_type      cmd
);
   import mur2_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MIXK = 3'd1;
   localparam logic [2:0] ST_MIXH = 3'd2;
   localparam logic [2:0] ST_TAIL = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;
   localparam logic [2:0] ST_EMIT = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       in_key_ff, in_key_in;
   logic       last_ff, last_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       acc;
   logic       go;

   assign req_stall = (state_ff != ST_IDLE);
   assign acc       = req_valid && !req_stall;
   assign go        = req_first_word || in_key_ff;

   always_comb begin
      state_in  = state_ff;
      in_key_in = in_key_ff;
      last_in   = last_ff;
      cmd.op    = OP_NONE;
      cmd.first = req_first_word;
      case (state_ff)
         ST_IDLE: begin
            if (acc && go) begin
               cmd.op    = OP_LOAD;
               in_key_in = !req_last_word;
               last_in   = req_last_word;
               if (req_byte_count[2]) begin
                  state_in = ST_MIXK;
               end else if (req_byte_count[1:0] != 2'd0) begin
                  state_in = ST_TAIL;
               end else if (req_last_word) begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_MIXK: begin
            cmd.op   = OP_MIXK;
            state_in = ST_MIXH;
         end
         ST_MIXH: begin
            cmd.op   = OP_MIXH;
            state_in = last_ff ? ST_FIN : ST_IDLE;
         end
         ST_TAIL: begin
            cmd.op   = OP_TAIL;
            state_in = last_ff ? ST_FIN : ST_IDLE;
         end
         ST_FIN: begin
            cmd.op   = OP_FIN;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.op   = OP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = (cmd.op == OP_EMIT) || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_key_ff    <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_key_ff    <= in_key_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `CHK_ASSERT(a_full_word_mixes, clock, reset,
      (acc && go && req_byte_count[2]) |=> (state_ff == ST_MIXK),
      "full word did not enter mixing")
   `CHK_ASSERT(a_emit_waits, clock, reset,
      (state_ff == ST_EMIT && rsp_valid_ff && rsp_stall) |=> (state_ff == ST_EMIT),
      "result overwritten while stalled")
   `CHK_NEVER(a_key_closed_in_final, clock, reset,
      (state_ff == ST_FIN || state_ff == ST_EMIT) && in_key_ff,
      "key still open during finalization")

endmodule

`default_nettype wire

// ===== rtl/murmur2_hash32_unit.sv =====
// ---------------------------------------------------------------------------
// murmur2_hash32_unit
// Streaming 32-bit MurmurHash2 of a key sent as little-endian words.
// ---------------------------------------------------------------------------
//
//   Channel   Direction   Handshake            Payload
//   req       in          req_valid/req_stall  word_data, byte_count,
//                                              key_length, first_word, last_word
//   rsp       out         rsp_valid/rsp_stall  hash_value
//
// A full word is loaded, mixed, then folded into the hash; a partial word is loaded
// then tail-mixed; an empty non-last word is only loaded. A last word adds finalize,
// then load the output register. The steps run in series on the single shared multiplier.
// Reset is synchronous and active high; it clears the sequencer state.
// A finished hash waits in the output register while rsp_stall is high;
// the unit keeps taking words until the next hash needs that register.
// ---------------------------------------------------------------------------
`default_nettype none

module murmur2_hash32_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_word_data,
   input  wire logic [2:0]  req_byte_count,
   input  wire logic [31:0] req_key_length,
   input  wire logic        req_first_word,
   input  wire logic        req_last_word,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_hash_value
);
   import mur2_pkg::*;

   // The controller issues one datapath operation per cycle, none while it waits.
   cmd_type cmd;

   // The controller owns the handshakes and the open-key flag.
   mur2_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_byte_count (req_byte_count),
      .req_first_word (req_first_word),
      .req_last_word  (req_last_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .cmd            (cmd)
   );

   // The datapath holds the running hash, the mixed word and the result.
   // Only the low two count bits matter there; the controller decodes the
   // full-word case from the top bit.
   mur2_datapath u_datapath (
      .clock          (clock),
      .cmd            (cmd),
      .req_word_data  (req_word_data),
      .req_byte_count (req_byte_count[1:0]),
      .req_key_length (req_key_length),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule

`default_nettype wire
